// File: rtl/assert_macros.svh
// Assertion helpers included by sector_wedge_fiducial_cut.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication a fixed number of cycles later
`define CHK_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);
`else
`define CHK_IMPL(label, clk, rst, ante, cons, msg)
`define CHK_DELAY(label, clk, rst, ante, n, cons, msg)
`endif
`endif

// File: rtl/swfc_pkg.sv
package swfc_pkg;

  // tightness codes
  localparam logic [1:0] TIGHT_TIGHT  = 2'd0;
  localparam logic [1:0] TIGHT_MEDIUM = 2'd1;
  localparam logic [1:0] TIGHT_LOOSE  = 2'd2;

  // field polarity codes
  localparam logic [1:0] POL_NONE = 2'd0;
  localparam logic [1:0] POL_INB  = 2'd1;
  localparam logic [1:0] POL_OUTB = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_TIGHTNESS = 1'b0;
  localparam logic REG_POLARITY  = 1'b1;

  // sqrt(3)/2 in Q0.16
  localparam logic [15:0] Q_HALF_SQRT3 = 16'd56755;
  // sqrt(3) in Q1.16, rounded on its own (not twice the half value)
  localparam logic [16:0] Q_SQRT3 = 17'd113512;

  // height / radius in cm
  typedef logic [6:0] lim_t;

  typedef struct packed {
    lim_t height;
    lim_t radius;
  } limits_t;

  // rotation coefficients: cos = +-1 or +-1/2, sin = 0 or +-sqrt(3)/2
  typedef struct packed {
    logic cos_neg;
    logic cos_half;
    logic sin_pos;
    logic sin_neg;
  } rot_sel_t;

  // angle index is (sector-1) mod 6 over the 3-bit sector code
  function automatic rot_sel_t rot_select(logic [2:0] sector);
    rot_sel_t s;
    s = '0;
    case (sector)
      3'd1, 3'd7: begin s.cos_neg = 1'b0; s.cos_half = 1'b0; end
      3'd2: begin s.cos_half = 1'b1; s.sin_pos = 1'b1; end
      3'd3: begin s.cos_neg = 1'b1; s.cos_half = 1'b1; s.sin_pos = 1'b1; end
      3'd4: begin s.cos_neg = 1'b1; end
      3'd5: begin s.cos_neg = 1'b1; s.cos_half = 1'b1; s.sin_neg = 1'b1; end
      3'd6, 3'd0: begin s.cos_half = 1'b1; s.sin_neg = 1'b1; end
      default: s = '0;
    endcase
    return s;
  endfunction

  // wedge height and circle radius for one hit
  function automatic limits_t lookup_limits(logic [1:0] pol, logic [1:0] tight,
                                            logic [1:0] region, logic [2:0] sector);
    limits_t lim;
    lim_t    k;
    logic    corner;
    logic    use_tab;
    k       = {5'd0, region};
    corner  = (sector == 3'd1) || (sector == 3'd4);
    use_tab = (sector inside {[3'd1:3'd6]}) && (pol == POL_INB || pol == POL_OUTB);
    // region defaults
    case (region)
      2'd1:    begin lim.height = 7'd29; lim.radius = 7'd29; end
      2'd2:    begin lim.height = 7'd35; lim.radius = 7'd40; end
      2'd3:    begin lim.height = 7'd48; lim.radius = 7'd49; end
      default: begin lim.height = 7'd0;  lim.radius = 7'd0;  end
    endcase
    if (use_tab) begin
      if (pol == POL_INB) begin
        case (region)
          2'd1:    begin lim.height = corner ? 7'd27 : 7'd22; lim.radius = 7'd29; end
          2'd2:    begin lim.height = corner ? 7'd40 : 7'd34; lim.radius = 7'd38; end
          2'd3:    begin lim.height = corner ? 7'd47 : 7'd39; lim.radius = 7'd50; end
          default: begin lim.height = 7'd0; lim.radius = 7'd0; end
        endcase
      end else begin
        case (region)
          2'd1:    begin lim.height = 7'd15; lim.radius = 7'd25; end
          2'd2:    begin lim.height = 7'd25; lim.radius = 7'd39; end
          2'd3:    begin lim.height = 7'd48; lim.radius = 7'd65; end
          default: begin lim.height = 7'd0;  lim.radius = 7'd0;  end
        endcase
      end
      // tightness offset of region-number cm
      if (tight == TIGHT_TIGHT) begin
        lim.height = lim.height + k;
        lim.radius = lim.radius + k;
      end else if (tight == TIGHT_LOOSE) begin
        lim.height = lim.height - k;
        lim.radius = lim.radius - k;
      end
    end
    return lim;
  endfunction

endpackage

// File: rtl/swfc_rotate.sv
// Two-stage rotation of a hit into its sector frame.
// Stage 1: products by sqrt(3)/2 and shifted cos terms.
// Stage 2: sums, then floor by 8 bits.
module swfc_rotate #(
  parameter int COORD_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  swfc_pkg::rot_sel_t            sel,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  output logic                          out_vld,
  output logic signed [COORD_BITS+9:0]  xr,
  output logic signed [COORD_BITS+9:0]  yr
);

  localparam int PW = COORD_BITS + 17;
  localparam int SW = COORD_BITS + 18;
  localparam int XW = SW - 8;

  localparam logic signed [16:0] K_SIN = {1'b0, swfc_pkg::Q_HALF_SQRT3};

  logic                 vld1;
  swfc_pkg::rot_sel_t   sel1;
  logic signed [PW-1:0] mx, my;
  logic signed [SW-1:0] cx, cy;
  logic signed [SW-1:0] px_ext, py_ext, px_sh, py_sh;
  logic signed [SW-1:0] sin_x, sin_y, sum_x, sum_y;

  // cos terms are shifts
  always_comb begin
    px_ext = SW'(px);
    py_ext = SW'(py);
    px_sh  = sel.cos_half ? (px_ext <<< 15) : (px_ext <<< 16);
    py_sh  = sel.cos_half ? (py_ext <<< 15) : (py_ext <<< 16);
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    sel1 <= sel;
    mx   <= PW'(px) * PW'(K_SIN);
    my   <= PW'(py) * PW'(K_SIN);
    cx   <= sel.cos_neg ? -px_sh : px_sh;
    cy   <= sel.cos_neg ? -py_sh : py_sh;
  end

  // x' = y*sin + x*cos, y' = y*cos - x*sin
  always_comb begin
    sin_y = sel1.sin_pos ? SW'(my) : (sel1.sin_neg ? -SW'(my) : '0);
    sin_x = sel1.sin_pos ? SW'(mx) : (sel1.sin_neg ? -SW'(mx) : '0);
    sum_x = cx + sin_y;
    sum_y = cy - sin_x;
  end

  // stage 2: arithmetic shift floors
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    xr <= XW'(sum_x >>> 8);
    yr <= XW'(sum_y >>> 8);
  end

endmodule

// File: rtl/sector_wedge_fiducial_cut.sv
// Channel   Signals                                    Direction
// --------  -----------------------------------------  ---------
// config    psel penable pwrite paddr pwdata prdata    in/out
// hit       start busy region sector pos_x pos_y       in/out
// result    done inside_res                            out
//
// One hit per cycle; busy is always low. Each hit's result passes through the
// six register stages (two for the rotation, then abs, squares, wedge/circle
// sums and the final compare).
// Reset clears every stage valid and sets tightness medium, polarity inbending.
// The result strobe done is high for one cycle per transaction; no stalls.
module sector_wedge_fiducial_cut #(
  parameter int COORD_BITS      = 18,
  parameter int COORD_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    region,
  input  logic [2:0]                    sector,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  output logic                          done,
  output logic                          inside_res
);

  `include "assert_macros.svh"

  localparam int XW   = COORD_BITS + 10;
  localparam int AW   = XW;
  localparam int SQB  = (AW < 31) ? AW : 31;
  localparam int SQW  = 2 * SQB;
  localparam int PYW  = AW + 16;
  localparam int CIRW = 2 * COORD_FRAC_BITS + 64;
  localparam int LW   = COORD_BITS + COORD_FRAC_BITS + 32;

  // ---------------- configuration registers ----------------
  logic [1:0] tightness;
  logic [1:0] field_polarity;

  always_ff @(posedge clk) begin
    if (rst) begin
      tightness      <= swfc_pkg::TIGHT_MEDIUM;
      field_polarity <= swfc_pkg::POL_INB;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        swfc_pkg::REG_TIGHTNESS: tightness      <= pwdata[1:0];
        swfc_pkg::REG_POLARITY:  field_polarity <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      swfc_pkg::REG_TIGHTNESS: prdata = {30'd0, tightness};
      swfc_pkg::REG_POLARITY:  prdata = {30'd0, field_polarity};
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // ---------------- stages 1-2: rotation + limits sideband ----------------
  logic                  acc;
  logic                  rot_vld;
  logic signed [XW-1:0]  xr, yr;
  swfc_pkg::limits_t     lim1;
  logic                  ok1;
  logic [6:0]            h2;
  logic [13:0]           rsq2;
  logic                  ok2;

  assign acc = start && !busy;

  swfc_rotate #(
    .COORD_BITS(COORD_BITS)
  ) u_rotate (
    .clk    (clk),
    .rst    (rst),
    .in_vld (acc),
    .sel    (swfc_pkg::rot_select(sector)),
    .px     (pos_x),
    .py     (pos_y),
    .out_vld(rot_vld),
    .xr     (xr),
    .yr     (yr)
  );

  always_ff @(posedge clk) begin
    lim1 <= swfc_pkg::lookup_limits(field_polarity, tightness, region, sector);
    ok1  <= (region != 2'd0);
    h2   <= lim1.height;
    rsq2 <= 14'(lim1.radius) * 14'(lim1.radius);
    ok2  <= ok1;
  end

  // ---------------- stage 3: magnitudes ----------------
  logic                  v3, ok3;
  logic signed [XW-1:0]  x3;
  logic [AW-1:0]         ax3, ay3;
  logic [6:0]            h3;
  logic [13:0]           rsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= rot_vld;
    end
    x3   <= xr;
    ax3  <= xr[XW-1] ? unsigned'(-xr) : unsigned'(xr);
    ay3  <= yr[XW-1] ? unsigned'(-yr) : unsigned'(yr);
    h3   <= h2;
    rsq3 <= rsq2;
    ok3  <= ok2;
  end

  // magnitude of 2^31 or more passes the circle outright
  logic big3;
  generate
    if (AW > 31) begin : g_big
      assign big3 = (|ax3[AW-1:31]) || (|ay3[AW-1:31]);
    end else begin : g_nobig
      assign big3 = 1'b0;
    end
  endgenerate

  // ---------------- stage 4: squares and sqrt(3)*|y| ----------------
  logic                  v4, ok4, big4;
  logic signed [XW-1:0]  x4;
  logic [SQW-1:0]        sqx4, sqy4;
  logic [PYW-1:0]        py4;
  logic [6:0]            h4;
  logic [13:0]           rsq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    x4   <= x3;
    sqx4 <= SQW'(ax3[SQB-1:0]) * SQW'(ax3[SQB-1:0]);
    sqy4 <= SQW'(ay3[SQB-1:0]) * SQW'(ay3[SQB-1:0]);
    py4  <= PYW'(ay3) * PYW'(swfc_pkg::Q_SQRT3);
    big4 <= big3;
    h4   <= h3;
    rsq4 <= rsq3;
    ok4  <= ok3;
  end

  // ---------------- stage 5: wedge left side, circle test ----------------
  logic                  v5, ok5, circ5;
  logic signed [LW-1:0]  lhs5;
  logic [6:0]            h5;
  logic [CIRW-1:0]       sum_sq, r2;

  always_comb begin
    sum_sq = CIRW'(sqx4) + CIRW'(sqy4);
    r2     = CIRW'(rsq4) << (2 * COORD_FRAC_BITS + 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    lhs5  <= (LW'(x4) <<< 16) - LW'(py4);
    circ5 <= big4 || (sum_sq > r2);
    h5    <= h4;
    ok5   <= ok4;
  end

  // ---------------- stage 6: wedge compare, result ----------------
  logic signed [LW-1:0] rhs;

  assign rhs = LW'(h5) << (COORD_FRAC_BITS + 24);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    inside_res <= ok5 && circ5 && (lhs5 > rhs);
  end

  // ---------------- checks ----------------
  `CHK_IMPL(a_done_follows_start, clk, rst, done, $past(start && !busy, 6), "result without hit")
  `CHK_DELAY(a_region0_fails, clk, rst, start && !busy && region == 2'd0, 6, done && !inside_res, "region 0 passed")
  `CHK_DELAY(a_origin_fails, clk, rst, start && !busy && pos_x == '0 && pos_y == '0, 6, done && !inside_res, "origin passed")

endmodule
